>>> src/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Holds field widths, status codes and the controller/datapath interface types.
// No dependencies.
package ffha_pkg;

    // default geometry
    localparam int DEF_ARENA_BYTES  = 4096;
    localparam int DEF_HEADER_BYTES = 16;
    localparam int DEF_MAX_CHUNKS   = 256;

    // request and result field widths
    localparam int OPC_W    = 1;
    localparam int REQ_W    = 16;
    localparam int OFF_W    = 12;
    localparam int BYTES_W  = 12;
    localparam int STATUS_W = 2;

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // result tdata layout: data_offset, block_bytes, did_split, zero fill
    localparam int SPLIT_BIT = OFF_W + BYTES_W;
    localparam int M_PAD_W   = M_TDATA_W - (OFF_W + BYTES_W + 1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

    // datapath commands, one per cycle from the controller
    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,      // latch the request
        CMD_START,     // rewind the walk, read entry 0
        CMD_STEP,      // advance the walk by one chunk
        CMD_FAIL,      // post a failure result
        CMD_A_HIT,     // allocate found its chunk, set up right shift
        CMD_F_HIT,     // free found its chunk, start the merge scan
        CMD_M_STEP,    // absorb one following free chunk
        CMD_M_END,     // set up left shift over the merged run
        CMD_SHIFT,     // one move of the table shift
        CMD_WR_TAIL,   // write the split remainder
        CMD_WR_HEAD    // write the chosen chunk, post the result
    } ffha_cmd_t;

    // datapath status back to the controller
    typedef struct packed {
        logic is_free;    // request is a free
        logic is_null;    // free of offset zero
        logic hit;        // current entry matches the request
        logic last;       // current entry is the last chunk
        logic split_due;  // current entry would be split
        logic m_free;     // merge candidate is free
        logic m_last;     // merge candidate is the last chunk
        logic sh_idle;    // table shift has nothing left
    } ffha_sts_t;

endpackage

>>> src/ffha_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/ffha_ctrl.sv
// Controller for the first-fit heap allocator: sequences walk, merge, shift
// and write-back. Depends on ffha_pkg.
module ffha_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                out_free,
    output logic                load_out,
    input  ffha_pkg::ffha_sts_t sts,
    output ffha_pkg::ffha_cmd_t cmd
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_A_SCAN,
        S_F_SCAN,
        S_M_SCAN,
        S_M_END,
        S_SHIFT,
        S_WR_TAIL,
        S_WR_HEAD,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   tready_reg, tready_next;

    assign s_tready = tready_reg;

    always_comb begin
        state_next  = state_reg;
        tready_next = tready_reg;
        cmd         = CMD_NOP;
        load_out    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && tready_reg) begin
                    cmd         = CMD_LOAD;
                    tready_next = 1'b0;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.is_free && sts.is_null) begin
                    cmd        = CMD_FAIL;
                    state_next = S_DONE;
                end else begin
                    cmd        = CMD_START;
                    state_next = sts.is_free ? S_F_SCAN : S_A_SCAN;
                end
            end
            S_A_SCAN: begin
                if (sts.hit) begin
                    cmd        = CMD_A_HIT;
                    state_next = sts.split_due ? S_SHIFT : S_WR_HEAD;
                end else if (sts.last) begin
                    cmd        = CMD_FAIL;
                    state_next = S_DONE;
                end else begin
                    cmd = CMD_STEP;
                end
            end
            S_F_SCAN: begin
                if (sts.hit) begin
                    cmd        = CMD_F_HIT;
                    state_next = sts.last ? S_M_END : S_M_SCAN;
                end else if (sts.last) begin
                    cmd        = CMD_FAIL;
                    state_next = S_DONE;
                end else begin
                    cmd = CMD_STEP;
                end
            end
            S_M_SCAN: begin
                if (sts.m_free) begin
                    cmd = CMD_M_STEP;
                    if (sts.m_last) begin
                        state_next = S_M_END;
                    end
                end else begin
                    state_next = S_M_END;
                end
            end
            S_M_END: begin
                cmd        = CMD_M_END;
                state_next = S_SHIFT;
            end
            S_SHIFT: begin
                if (sts.sh_idle) begin
                    state_next = sts.is_free ? S_WR_HEAD : S_WR_TAIL;
                end else begin
                    cmd = CMD_SHIFT;
                end
            end
            S_WR_TAIL: begin
                cmd        = CMD_WR_TAIL;
                state_next = S_WR_HEAD;
            end
            S_WR_HEAD: begin
                cmd        = CMD_WR_HEAD;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    tready_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next  = S_IDLE;
                tready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            tready_reg <= 1'b1;
        end else begin
            state_reg  <= state_next;
            tready_reg <= tready_next;
        end
    end

endmodule

>>> src/ffha_dp.sv
// Datapath for the first-fit heap allocator: chunk table RAM, walk position,
// merge accumulator, table shifter and result registers.
// Depends on ffha_pkg and ffha_ram.
module ffha_dp #(
    parameter int ARENA_BYTES  = ffha_pkg::DEF_ARENA_BYTES,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
    parameter int MAX_CHUNKS   = ffha_pkg::DEF_MAX_CHUNKS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ffha_pkg::ffha_cmd_t           cmd,
    output ffha_pkg::ffha_sts_t           sts,
    input  logic                          in_opcode,
    input  logic [ffha_pkg::REQ_W-1:0]    in_request_size,
    input  logic [ffha_pkg::OFF_W-1:0]    in_block_offset,
    output logic [ffha_pkg::STATUS_W-1:0] res_status,
    output logic [ffha_pkg::OFF_W-1:0]    res_data_offset,
    output logic [ffha_pkg::BYTES_W-1:0]  res_block_bytes,
    output logic                          res_did_split
);
    import ffha_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = IDX_W + 1;
    localparam int SZ_W  = $clog2(ARENA_BYTES);
    localparam int POS_W = SZ_W + 1;
    localparam int ENT_W = SZ_W + 1;
    localparam int CMP_W = ((SZ_W > REQ_W) ? SZ_W : REQ_W) + 1;
    localparam int OC_W  = ((POS_W > OFF_W) ? POS_W : OFF_W) + 1;

    localparam logic [SZ_W-1:0]  INIT_SIZE = SZ_W'(ARENA_BYTES - HEADER_BYTES);
    localparam logic [SZ_W-1:0]  HDR_S     = SZ_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] HDR_P     = POS_W'(HEADER_BYTES);
    localparam logic [CMP_W-1:0] HDR_C     = CMP_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_CHUNKS);

    // control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic             init0_reg, init0_next;   // entry 0 has been written
    logic             rd_rst_reg, rd_rst_next; // read data stands for the reset entry
    logic             sh_wv_reg, sh_wv_next;
    logic [CNT_W-1:0] sh_left_reg, sh_left_next;

    // payload
    logic                op_reg, op_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SZ_W-1:0]     cur_reg, cur_next;
    logic [SZ_W-1:0]     acc_reg, acc_next;
    logic                split_reg, split_next;
    logic                sh_dir_reg, sh_dir_next;    // 1: move up one slot
    logic [IDX_W-1:0]    sh_rd_reg, sh_rd_next;
    logic [IDX_W-1:0]    sh_wa_reg, sh_wa_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [OFF_W-1:0]    doff_reg, doff_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic                dsplit_reg, dsplit_next;

    // RAM port
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;

    logic [ENT_W-1:0] rd_entry;
    logic             rd_busy;
    logic [SZ_W-1:0]  rd_size;
    logic [CNT_W-1:0] idx_inc, j_inc;
    logic [CMP_W-1:0] sz_c, req_c;
    logic [OC_W-1:0]  pos_hdr_c;
    logic [POS_W-1:0] pos_hdr;
    logic [SZ_W-1:0]  fin_size;

    ffha_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_CHUNKS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // entry 0 reads as the whole-arena free chunk until first written
    assign rd_entry = rd_rst_reg ? {1'b0, INIT_SIZE} : ram_rdata;
    assign rd_busy  = rd_entry[SZ_W];
    assign rd_size  = rd_entry[SZ_W-1:0];

    assign idx_inc   = idx_reg + 1'b1;
    assign j_inc     = j_reg + 1'b1;
    assign sz_c      = CMP_W'(rd_size);
    assign req_c     = CMP_W'(req_reg);
    assign pos_hdr   = pos_reg + HDR_P;
    assign pos_hdr_c = OC_W'(pos_hdr);
    assign fin_size  = split_reg ? SZ_W'(req_reg) : cur_reg;

    always_comb begin
        sts.is_free   = (op_reg == OP_FREE);
        sts.is_null   = (off_reg == '0);
        sts.hit       = (op_reg == OP_FREE) ? (pos_hdr_c == OC_W'(off_reg))
                                            : (!rd_busy && (sz_c >= req_c));
        sts.last      = (idx_inc == count_reg);
        sts.split_due = (sz_c > req_c + HDR_C) && (count_reg < MAX_CNT);
        sts.m_free    = !rd_busy;
        sts.m_last    = (j_inc == count_reg);
        sts.sh_idle   = (sh_left_reg == '0) && !sh_wv_reg;
    end

    always_comb begin
        count_next   = count_reg;
        sh_wv_next   = sh_wv_reg;
        sh_left_next = sh_left_reg;
        op_next      = op_reg;
        req_next     = req_reg;
        off_next     = off_reg;
        idx_next     = idx_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        acc_next     = acc_reg;
        split_next   = split_reg;
        sh_dir_next  = sh_dir_reg;
        sh_rd_next   = sh_rd_reg;
        sh_wa_next   = sh_wa_reg;
        st_next      = st_reg;
        doff_next    = doff_reg;
        bytes_next   = bytes_reg;
        dsplit_next  = dsplit_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        case (cmd)
            CMD_LOAD: begin
                op_next  = in_opcode;
                req_next = in_request_size;
                off_next = in_block_offset;
            end
            CMD_START: begin
                idx_next  = '0;
                pos_next  = '0;
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            CMD_STEP: begin
                idx_next  = idx_inc;
                pos_next  = pos_hdr + POS_W'(rd_size);
                ram_re    = 1'b1;
                ram_raddr = idx_inc[IDX_W-1:0];
            end
            CMD_FAIL: begin
                if (op_reg == OP_FREE) begin
                    st_next = (off_reg == '0) ? ST_NULL : ST_UNKNOWN;
                end else begin
                    st_next = ST_NOFIT;
                end
                doff_next   = '0;
                bytes_next  = '0;
                dsplit_next = 1'b0;
            end
            CMD_A_HIT: begin
                cur_next     = rd_size;
                split_next   = sts.split_due;
                sh_dir_next  = 1'b1;
                sh_rd_next   = IDX_W'(count_reg - 1'b1);
                sh_left_next = count_reg - 1'b1 - idx_reg;
                sh_wv_next   = 1'b0;
            end
            CMD_F_HIT: begin
                acc_next  = rd_size;
                k_next    = '0;
                j_next    = idx_inc;
                ram_re    = 1'b1;
                ram_raddr = idx_inc[IDX_W-1:0];
            end
            CMD_M_STEP: begin
                acc_next  = acc_reg + HDR_S + rd_size;
                k_next    = k_reg + 1'b1;
                j_next    = j_inc;
                ram_re    = 1'b1;
                ram_raddr = j_inc[IDX_W-1:0];
            end
            CMD_M_END: begin
                sh_dir_next  = 1'b0;
                sh_rd_next   = IDX_W'(idx_inc + k_reg);
                sh_left_next = (k_reg == '0) ? '0 : (count_reg - 1'b1 - idx_reg - k_reg);
                sh_wv_next   = 1'b0;
            end
            CMD_SHIFT: begin
                // read one slot, write it to its new place on the next cycle
                if (sh_wv_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = sh_wa_reg;
                    ram_wdata = rd_entry;
                end
                if (sh_left_reg != '0) begin
                    ram_re       = 1'b1;
                    ram_raddr    = sh_rd_reg;
                    sh_wa_next   = sh_dir_reg ? (sh_rd_reg + 1'b1)
                                              : (sh_rd_reg - k_reg[IDX_W-1:0]);
                    sh_rd_next   = sh_dir_reg ? (sh_rd_reg - 1'b1) : (sh_rd_reg + 1'b1);
                    sh_left_next = sh_left_reg - 1'b1;
                    sh_wv_next   = 1'b1;
                end else begin
                    sh_wv_next = 1'b0;
                end
            end
            CMD_WR_TAIL: begin
                ram_we    = 1'b1;
                ram_waddr = idx_inc[IDX_W-1:0];
                ram_wdata = {1'b0, SZ_W'(CMP_W'(cur_reg) - req_c - HDR_C)};
            end
            CMD_WR_HEAD: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IDX_W-1:0];
                st_next   = ST_OK;
                if (op_reg == OP_FREE) begin
                    ram_wdata   = {1'b0, acc_reg};
                    count_next  = count_reg - k_reg;
                    doff_next   = off_reg;
                    bytes_next  = BYTES_W'(acc_reg);
                    dsplit_next = 1'b0;
                end else begin
                    ram_wdata   = {1'b1, fin_size};
                    count_next  = count_reg + CNT_W'(split_reg);
                    doff_next   = OFF_W'(pos_hdr);
                    bytes_next  = BYTES_W'(fin_size);
                    dsplit_next = split_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign init0_next  = init0_reg | (ram_we && (ram_waddr == '0));
    assign rd_rst_next = ram_re ? ((ram_raddr == '0) && !init0_reg) : rd_rst_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= CNT_W'(1);
            init0_reg   <= 1'b0;
            rd_rst_reg  <= 1'b0;
            sh_wv_reg   <= 1'b0;
            sh_left_reg <= '0;
        end else begin
            count_reg   <= count_next;
            init0_reg   <= init0_next;
            rd_rst_reg  <= rd_rst_next;
            sh_wv_reg   <= sh_wv_next;
            sh_left_reg <= sh_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        req_reg    <= req_next;
        off_reg    <= off_next;
        idx_reg    <= idx_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        acc_reg    <= acc_next;
        split_reg  <= split_next;
        sh_dir_reg <= sh_dir_next;
        sh_rd_reg  <= sh_rd_next;
        sh_wa_reg  <= sh_wa_next;
        st_reg     <= st_next;
        doff_reg   <= doff_next;
        bytes_reg  <= bytes_next;
        dsplit_reg <= dsplit_next;
    end

    assign res_status      = st_reg;
    assign res_data_offset = doff_reg;
    assign res_block_bytes = bytes_reg;
    assign res_did_split   = dsplit_reg;

endmodule

>>> src/first_fit_heap_allocator_top.sv
// First-fit heap allocator, top level: stream ports, result register,
// controller and datapath. Depends on ffha_pkg, ffha_ctrl, ffha_dp.
//
// Usage:
//   Requests arrive on the s_ channel, one transfer per request: s_tuser[0]
//   is the opcode (0 allocate, 1 free), s_tdata carries request_size and
//   block_offset. Every request yields exactly one result transfer on the m_
//   channel: m_tuser is the status, m_tdata carries data_offset, block_bytes
//   and did_split.
//   The arena is kept as an address-ordered chunk table in one RAM with a
//   registered read port. Requests are handled one at a time; s_tready is
//   high only while the block is idle.
//   From accept to m_tvalid: a null free goes from dispatch straight to its
//   failure result. Any other request passes a dispatch state, then walks the
//   table at one entry per cycle; a free then reads the following free chunks
//   it merges, one per cycle, and closes the run.
//   A split or merge moves the tail of the table one entry per cycle through
//   the RAM port and drains the last write; write-back and result load follow.
//   One request is in work at a time; the next can be accepted in the cycle
//   after the previous result is loaded.
//   Reset (aresetn low, synchronous) leaves one free chunk that spans the
//   arena; no RAM clearing pass is needed, the first request may follow.
//   The result sits in an output register: the next request is accepted
//   while it waits. If m_tready stays low, the following result is held in
//   the datapath until the register frees up.
module first_fit_heap_allocator_top #(
    parameter int ARENA_BYTES  = ffha_pkg::DEF_ARENA_BYTES,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
    parameter int MAX_CHUNKS   = ffha_pkg::DEF_MAX_CHUNKS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ffha_pkg::S_TDATA_W-1:0] s_tdata,  // [15:0] request_size, [27:16] block_offset
    input  logic [ffha_pkg::S_TUSER_W-1:0] s_tuser,  // [0] opcode
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ffha_pkg::M_TDATA_W-1:0] m_tdata,  // [11:0] data_offset, [23:12] block_bytes,
                                                     // [24] did_split
    output logic [ffha_pkg::M_TUSER_W-1:0] m_tuser   // [1:0] status
);
    import ffha_pkg::*;

    ffha_cmd_t cmd;
    ffha_sts_t sts;
    logic      load_out;
    logic      out_free;

    logic [STATUS_W-1:0] res_status;
    logic [OFF_W-1:0]    res_data_offset;
    logic [BYTES_W-1:0]  res_block_bytes;
    logic                res_did_split;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // result register can take a new result when empty or draining now
    assign out_free = !m_tvalid_reg || m_tready;

    ffha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .out_free(out_free),
        .load_out(load_out),
        .sts     (sts),
        .cmd     (cmd)
    );

    ffha_dp #(
        .ARENA_BYTES (ARENA_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .MAX_CHUNKS  (MAX_CHUNKS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_opcode      (s_tuser[0]),
        .in_request_size(s_tdata[REQ_W-1:0]),
        .in_block_offset(s_tdata[REQ_W+OFF_W-1:REQ_W]),
        .res_status     (res_status),
        .res_data_offset(res_data_offset),
        .res_block_bytes(res_block_bytes),
        .res_did_split  (res_did_split)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{M_PAD_W{1'b0}}, res_did_split, res_block_bytes, res_data_offset};
            m_tuser_next  = res_status;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> src/ffha_checker.sv
// Port-level checks for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_top.
module ffha_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ffha_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ffha_pkg::M_TUSER_W-1:0] m_tuser
);
    import ffha_pkg::*;

    // no result is pending right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one request at a time: no accept on the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // failed requests carry no offset, size or split flag
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[SPLIT_BIT:0] == '0))
        else $error("failure result with nonzero payload");

    // only a successful request can report a split
    a_split_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[SPLIT_BIT] |-> (m_tuser == ST_OK))
        else $error("split reported on a failed request");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

>>> tb/sv/ffha_checker.sv
// Result checker for the first-fit heap allocator: watches the request and result
// channels, keeps its own copy of the chunk table and compares every result transfer.
// Depends on ffha_pkg.
module ffha_scoreboard #(
    parameter int ARENA_BYTES  = ffha_pkg::DEF_ARENA_BYTES,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
    parameter int MAX_CHUNKS   = ffha_pkg::DEF_MAX_CHUNKS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ffha_pkg::S_TDATA_W-1:0] s_tdata,  // [15:0] request_size, [27:16] block_offset
    input  logic [ffha_pkg::S_TUSER_W-1:0] s_tuser,  // [0] opcode
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ffha_pkg::M_TDATA_W-1:0] m_tdata,  // [11:0] data_offset, [23:12] block_bytes,
                                                     // [24] did_split
    input  logic [ffha_pkg::M_TUSER_W-1:0] m_tuser,  // [1:0] status
    output int unsigned                    error_total,
    output int unsigned                    pending_total
);
    import ffha_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    data_offset;
        logic [BYTES_W-1:0]  block_bytes;
        logic                did_split;
    } heap_reply_t;

    heap_reply_t  replies_due[$];

    // chunk table in address order
    int unsigned  chunk_len [MAX_CHUNKS];
    bit           chunk_taken [MAX_CHUNKS];
    int unsigned  chunk_total;

    function automatic heap_reply_t grant_first_fit(input int unsigned want_bytes);
        heap_reply_t reply;
        int unsigned pos;
        bit          split;
        reply        = '0;
        reply.status = ST_NOFIT;
        pos          = 0;
        for (int i = 0; i < int'(chunk_total); i++) begin
            if (!chunk_taken[i] && chunk_len[i] >= want_bytes) begin
                split = 1'b0;
                if (chunk_len[i] > want_bytes + HEADER_BYTES && chunk_total < MAX_CHUNKS) begin
                    for (int j = int'(chunk_total); j > i + 1; j--) begin
                        chunk_len[j]   = chunk_len[j-1];
                        chunk_taken[j] = chunk_taken[j-1];
                    end
                    chunk_len[i+1]   = chunk_len[i] - want_bytes - HEADER_BYTES;
                    chunk_taken[i+1] = 1'b0;
                    chunk_total++;
                    chunk_len[i] = want_bytes;
                    split        = 1'b1;
                end
                chunk_taken[i]    = 1'b1;
                reply.status      = ST_OK;
                reply.data_offset = OFF_W'(pos + HEADER_BYTES);
                reply.block_bytes = BYTES_W'(chunk_len[i]);
                reply.did_split   = split;
                return reply;
            end
            pos += HEADER_BYTES + chunk_len[i];
        end
        return reply;
    endfunction

    function automatic heap_reply_t release_and_merge(input int unsigned blk_off);
        heap_reply_t reply;
        int unsigned pos;
        reply = '0;
        if (blk_off == 0) begin
            reply.status = ST_NULL;
            return reply;
        end
        pos = 0;
        for (int i = 0; i < int'(chunk_total); i++) begin
            if (pos + HEADER_BYTES == blk_off) begin
                chunk_taken[i] = 1'b0;
                // forward merge only
                while (i + 1 < int'(chunk_total) && !chunk_taken[i+1]) begin
                    chunk_len[i] += HEADER_BYTES + chunk_len[i+1];
                    for (int j = i + 1; j + 1 < int'(chunk_total); j++) begin
                        chunk_len[j]   = chunk_len[j+1];
                        chunk_taken[j] = chunk_taken[j+1];
                    end
                    chunk_total--;
                    chunk_len[chunk_total]   = 0;
                    chunk_taken[chunk_total] = 1'b0;
                end
                reply.status      = ST_OK;
                reply.data_offset = OFF_W'(blk_off);
                reply.block_bytes = BYTES_W'(chunk_len[i]);
                return reply;
            end
            pos += HEADER_BYTES + chunk_len[i];
        end
        reply.status = ST_UNKNOWN;
        return reply;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            error_total++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        heap_reply_t got;
        heap_reply_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHUNKS; i++) begin
                chunk_len[i]   = 0;
                chunk_taken[i] = 1'b0;
            end
            chunk_len[0] = ARENA_BYTES - HEADER_BYTES;
            chunk_total  = 1;
            replies_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status      = m_tuser;
                got.data_offset = m_tdata[OFF_W-1:0];
                got.block_bytes = m_tdata[OFF_W +: BYTES_W];
                got.did_split   = m_tdata[SPLIT_BIT];
                if (replies_due.size() == 0) begin
                    error_total++;
                    $error("result transfer with no request pending: status %0d", got.status);
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("data_offset", want.data_offset, got.data_offset);
                    check_field("block_bytes", want.block_bytes, got.block_bytes);
                    check_field("did_split", want.did_split, got.did_split);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_ALLOC)
                    replies_due.push_back(grant_first_fit(s_tdata[REQ_W-1:0]));
                else
                    replies_due.push_back(release_and_merge(s_tdata[REQ_W +: OFF_W]));
            end
        end
        pending_total = replies_due.size();
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the first-fit heap allocator testbench: clock, reset, request stimulus,
// result-side back-pressure and the final verdict.
// Depends on ffha_pkg, first_fit_heap_allocator_top and ffha_scoreboard.
module testbench;
    import ffha_pkg::*;

    localparam int RANDOM_ITEMS = 1925;
    localparam int HOLD_CYCLES  = 1500;
    // well above the worst-case request latency, walk plus table shift
    localparam int DRAIN_CYCLES = 2 * DEF_MAX_CHUNKS + 8;
    localparam int CYCLE_LIMIT  = 4_000_000;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // [15:0] request_size, [27:16] block_offset
    logic [S_TUSER_W-1:0] s_tuser  = '0;  // [0] opcode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // [11:0] data_offset, [23:12] block_bytes, [24] did_split
    logic [M_TUSER_W-1:0] m_tuser;        // [1:0] status

    int unsigned          error_total;
    int unsigned          pending_total;
    int unsigned          cycle_count = 0;

    // stimulus bookkeeping
    bit                   idling      = 1'b1;  // random idle cycles on both sides
    int unsigned          holds_asked = 0;     // long receiver hold-offs requested
    int unsigned          holds_done  = 0;
    logic                 ops_in_flight[$];    // opcode of every accepted request, oldest first
    logic [OFF_W-1:0]     live_blocks[$];      // granted offsets not yet freed

    first_fit_heap_allocator_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ffha_scoreboard u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_total   (error_total),
        .pending_total (pending_total)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Track granted blocks so most frees name a live one. A result transfer
    // always belongs to the oldest accepted request.
    always @(posedge aclk) begin
        logic done_op;
        if (m_tvalid && m_tready && ops_in_flight.size() != 0) begin
            done_op = ops_in_flight.pop_front();
            if (done_op == OP_ALLOC && m_tuser == ST_OK)
                live_blocks.push_back(m_tdata[OFF_W-1:0]);
        end
    end

    // Result side: random ready with idle cycles, plus long hold-offs on request
    // that fill the block up and stall the request channel.
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && holds_done != holds_asked) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idling && $urandom_range(0, 99) < 16);
            end
        end
    end

    // One request transfer; tvalid stays high across back-to-back requests.
    task automatic send_req(input logic op, input logic [REQ_W-1:0] req_bytes,
                            input logic [OFF_W-1:0] blk_off);
        while (idling && $urandom_range(0, 99) < 16) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({blk_off, req_bytes});
        do @(posedge aclk); while (!s_tready);
        ops_in_flight.push_back(op);
    endtask

    initial begin : stimulus
        int unsigned      pick;
        int unsigned      free_pct;
        int unsigned      mode;
        int unsigned      k;
        logic             op;
        logic [REQ_W-1:0] req_bytes;
        logic [OFF_W-1:0] blk_off;

        mode = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: zero-size grant, oversize request, exact fits, full arena,
        // null and unknown frees, free of a free chunk, split boundary
        // (size == request + header gives no split), highest data offset,
        // and forward merges over runs of free chunks.
        send_req(OP_ALLOC, 16'd0,     12'd0);
        send_req(OP_ALLOC, 16'hFFFF,  12'd0);
        send_req(OP_ALLOC, 16'd4064,  12'd0);
        send_req(OP_ALLOC, 16'd1,     12'd0);
        send_req(OP_FREE,  16'd0,     12'd0);
        send_req(OP_FREE,  16'd0,     12'hFFF);
        send_req(OP_FREE,  16'd0,     12'd16);
        send_req(OP_FREE,  16'd0,     12'd16);
        send_req(OP_FREE,  16'd0,     12'd32);
        send_req(OP_FREE,  16'd0,     12'd16);
        send_req(OP_ALLOC, 16'd4080,  12'd0);
        send_req(OP_FREE,  16'd0,     12'd16);
        send_req(OP_ALLOC, 16'd4064,  12'd0);
        send_req(OP_FREE,  16'd0,     12'd16);
        send_req(OP_ALLOC, 16'd4063,  12'd0);
        send_req(OP_ALLOC, 16'd1,     12'd0);
        send_req(OP_FREE,  16'd0,     12'd4095);
        send_req(OP_FREE,  16'd0,     12'd16);
        send_req(OP_ALLOC, 16'd100,   12'd0);
        send_req(OP_ALLOC, 16'd200,   12'd0);
        send_req(OP_ALLOC, 16'd300,   12'd0);
        send_req(OP_FREE,  16'd0,     12'd132);
        send_req(OP_FREE,  16'd0,     12'd16);
        send_req(OP_FREE,  16'd0,     12'd348);
        send_req(OP_FREE,  16'd0,     12'd16);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_total != 0) @(negedge aclk);
        live_blocks.delete();

        // Random: blocks of 100 requests in a normal, fill (many tiny grants,
        // long table) or drain mode; most frees name a live block, a few are
        // repeated, null or arbitrary offsets.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                mode = $urandom_range(0, 3);
            idling = !(n >= 700 && n < 1000);
            if (n == 100 || n == 1300)
                holds_asked++;

            op        = OP_ALLOC;
            req_bytes = REQ_W'($urandom());
            blk_off   = OFF_W'($urandom());
            pick      = $urandom_range(0, 99);
            if (pick < 3) begin
                op      = OP_FREE;
                blk_off = '0;
            end else if (pick < 7) begin
                op      = OP_FREE;
                blk_off = OFF_W'($urandom_range(1, 4095));
            end else if (pick >= 10) begin
                free_pct = (mode == 2) ? 15 : (mode == 3) ? 80 :
                           (live_blocks.size() > 20) ? 60 : 40;
                if (live_blocks.size() != 0 && $urandom_range(0, 99) < free_pct) begin
                    op      = OP_FREE;
                    k       = $urandom_range(0, live_blocks.size() - 1);
                    blk_off = live_blocks[k];
                    // now and then keep it listed so it gets freed twice
                    if ($urandom_range(0, 19) != 0)
                        live_blocks.delete(k);
                end else if (mode == 2) begin
                    req_bytes = REQ_W'($urandom_range(0, 24));
                end else begin
                    k = $urandom_range(0, 9);
                    if (k < 4)
                        req_bytes = REQ_W'($urandom_range(0, 48));
                    else if (k < 8)
                        req_bytes = REQ_W'($urandom_range(49, 320));
                    else
                        req_bytes = REQ_W'($urandom_range(321, 4080));
                end
            end
            // pick 7..9 keeps the full 16-bit random size: mostly no fit
            send_req(op, req_bytes, blk_off);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        idling   = 1'b1;

        while (pending_total != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_total == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
